// ===== rtl/rfa_pkg.sv =====
// Shared types, constants and step functions for the radial falloff alpha pipeline.
package rfa_pkg;

   localparam int unsigned MAX_SIZE = 1024;
   localparam int unsigned SQ_STAGES = 10;
   localparam int unsigned DIV_STAGES = 9;
   localparam int unsigned POW_STAGES = 5;
   localparam int unsigned DIV0 = 1 + SQ_STAGES;
   localparam int unsigned POW0 = DIV0 + DIV_STAGES;
   localparam int unsigned PIPE_LEN = POW0 + POW_STAGES;

   localparam logic [1:0] REG_TEXTURE_WIDTH = 2'd0;
   localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd1;

   localparam logic [10:0] SIZE_MAX = 11'(MAX_SIZE);
   localparam logic [10:0] SIZE_RESET = 11'd256;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0]  alpha_byte;
      logic [21:0] byte_offset;
      logic        outside;
   } rsp_type;

   typedef struct packed {
      logic [21:0] byte_offset;
      logic        outside;
      logic        sat;
   } side_type;

   typedef struct packed {
      logic [39:0] rad;
      logic [21:0] rem;
      logic [19:0] root;
   } sq_lane_type;

   typedef struct packed {
      logic [18:0] rem;
      logic [16:0] quo;
   } div_lane_type;

   // One digit of the restoring square root: two radicand bits, one root bit.
   function automatic sq_lane_type sq_step(input sq_lane_type l);
      sq_lane_type r;
      logic [23:0] rem2;
      logic [23:0] trial;
      rem2 = {l.rem, l.rad[39:38]};
      trial = {2'b00, l.root, 2'b01};
      r.rad = {l.rad[37:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem = 22'(rem2 - trial);
         r.root = {l.root[18:0], 1'b1};
      end else begin
         r.rem = rem2[21:0];
         r.root = {l.root[18:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of the restoring division.
   function automatic div_lane_type div_step(input div_lane_type l, input logic [17:0] den);
      div_lane_type r;
      logic [19:0] rem2;
      rem2 = {l.rem, 1'b0};
      if (rem2 >= {2'b00, den}) begin
         r.rem = 19'(rem2 - {2'b00, den});
         r.quo = {l.quo[15:0], 1'b1};
      end else begin
         r.rem = rem2[18:0];
         r.quo = {l.quo[15:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/rfa_sqrt_pipe.sv =====
// Pipelined integer square root of a 40-bit radicand, two root bits per stage.
module rfa_sqrt_pipe
   import rfa_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [39:0] in_rad,
   output logic [19:0] out_root
);

   sq_lane_type lane_ff [SQ_STAGES];
   sq_lane_type lane_in [SQ_STAGES];

   always_comb begin
      sq_lane_type first;
      first.rad = in_rad;
      first.rem = '0;
      first.root = '0;
      lane_in[0] = sq_step(sq_step(first));
      for (int i = 1; i < SQ_STAGES; i++) begin
         lane_in[i] = sq_step(sq_step(lane_ff[i-1]));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < SQ_STAGES; i++) begin
            lane_ff[i] <= lane_in[i];
         end
      end
   end

   assign out_root = lane_ff[SQ_STAGES-1].root;

endmodule

// ===== rtl/radial_falloff_alpha.sv =====
// Top level of the radial falloff alpha pipeline.
//
// Each req_ beat carries one pixel coordinate; each rsp_ beat returns its alpha
// byte, RGBA byte offset and an outside flag, in order, one result per request.
// The user must write the texture width and height through the csr_ port
// only while idle; the block does not enforce this. Values above 1024
// saturate to 1024, and both reset to 256. A beat is accepted when valid is
// high and stall is low on its channel. Throughput is one pixel per cycle
// while the output is not stalled: the two square roots take ten stages of
// two subtract steps, the division nine (the first one subtract, the rest two)
// and the power chain five, one subtract or multiply each; all are registered.
// When rsp_stall is high while a response is shown, the whole pipeline holds
// and req_stall is raised, so nothing is lost or repeated.
// Reset is synchronous: it empties the pipeline and restores the registers.
module radial_falloff_alpha
   import rfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic [10:0] width_ff, height_ff;
   logic        advance;

   logic        valid_ff [PIPE_LEN];
   side_type    side_ff  [PIPE_LEN];
   side_type    side_in  [PIPE_LEN];

   logic [39:0] dist_rad_ff, reach_rad_ff;
   logic [19:0] dist_root, reach_root;

   div_lane_type div_ff    [DIV_STAGES];
   div_lane_type div_in    [DIV_STAGES];
   logic [17:0]  den_ff    [DIV_STAGES-1];

   logic [15:0] b_ff, b2_ff, b2_d1_ff, b2_d2_ff, b4_ff, b8_ff, b10_ff;
   logic [15:0] b_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        div_clamp;
   logic        ratio_zero;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Configuration registers.
   logic [10:0] csr_sat;
   assign csr_sat = (csr_wdata > SIZE_MAX) ? SIZE_MAX : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_TEXTURE_WIDTH:  width_ff <= csr_sat;
            REG_TEXTURE_HEIGHT: height_ff <= csr_sat;
            default: ;
         endcase
      end
   end

   // Entry stage: deltas in half pixels, squared distance and offset.
   logic signed [11:0] ex, ey;
   logic [22:0]        ex_sq, ey_sq;
   logic [23:0]        sq_sum;
   logic [20:0]        w_sq;
   logic [20:0]        row_base;
   logic [21:0]        offset;

   always_comb begin
      ex = $signed({1'b0, req_data.pixel_x, 1'b0}) - $signed({1'b0, width_ff});
      ey = $signed({1'b0, req_data.pixel_y, 1'b0}) - $signed({1'b0, width_ff});
      ex_sq = 23'($unsigned(24'(ex * ex)));
      ey_sq = 23'($unsigned(24'(ey * ey)));
      sq_sum = {1'b0, ex_sq} + {1'b0, ey_sq};
      w_sq = 21'(width_ff * width_ff);
      row_base = 21'(req_data.pixel_y * width_ff) + {11'd0, req_data.pixel_x};
      offset = {row_base[19:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_rad_ff <= {2'b00, sq_sum, 14'd0};
         reach_rad_ff <= {4'd0, w_sq, 15'd0};
      end
   end

   rfa_sqrt_pipe u_dist_sqrt (
      .clock    (clock),
      .enable   (advance),
      .in_rad   (dist_rad_ff),
      .out_root (dist_root)
   );

   rfa_sqrt_pipe u_reach_sqrt (
      .clock    (clock),
      .enable   (advance),
      .in_rad   (reach_rad_ff),
      .out_root (reach_root)
   );

   // Division: ratio = dist * 2^16 / reach, one quotient bit per step.
   always_comb begin
      div_lane_type first;
      logic [18:0] dist_q;
      logic [17:0] reach;
      dist_q = dist_root[18:0];
      reach = reach_root[17:0];
      div_clamp = (reach == 18'd0) || (dist_q >= {reach, 1'b0});
      if (dist_q >= {1'b0, reach}) begin
         first.rem = dist_q - {1'b0, reach};
         first.quo = 17'd1;
      end else begin
         first.rem = dist_q;
         first.quo = 17'd0;
      end
      div_in[0] = first;
      for (int i = 1; i < DIV_STAGES; i++) begin
         div_in[i] = div_step(div_step(div_ff[i-1], den_ff[i-1]), den_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= reach_root[17:0];
         for (int i = 0; i < DIV_STAGES; i++) begin
            div_ff[i] <= div_in[i];
         end
         for (int i = 1; i < DIV_STAGES-1; i++) begin
            den_ff[i] <= den_ff[i-1];
         end
      end
   end

   // Base |1 - ratio| in Q0.16; a zero ratio saturates alpha.
   logic [16:0] ratio;
   assign ratio = div_ff[DIV_STAGES-1].quo;
   assign ratio_zero = (ratio == 17'd0);

   always_comb begin
      if (ratio <= 17'h10000) begin
         b_in = 16'(17'h10000 - ratio);
      end else begin
         b_in = 16'(ratio - 17'h10000);
      end
   end

   logic [31:0] p2, p4, p8, p10;
   assign p2 = b_ff * b_ff;
   assign p4 = b2_ff * b2_ff;
   assign p8 = b4_ff * b4_ff;
   assign p10 = b8_ff * b2_d2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ff <= b_in;
         b2_ff <= p2[31:16];
         b2_d1_ff <= b2_ff;
         b4_ff <= p4[31:16];
         b2_d2_ff <= b2_d1_ff;
         b8_ff <= p8[31:16];
         b10_ff <= p10[31:16];
      end
   end

   // Side information travels with the valid bits; saturation joins on the way.
   always_comb begin
      side_in[0].byte_offset = offset;
      side_in[0].outside = ({1'b0, req_data.pixel_x} >= width_ff) ||
                           ({1'b0, req_data.pixel_y} >= height_ff);
      side_in[0].sat = 1'b0;
      for (int i = 1; i < PIPE_LEN; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[DIV0].sat = div_clamp;
      side_in[POW0].sat = side_ff[POW0-1].sat || ratio_zero;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LEN; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Output register.
   logic [23:0] scaled;
   rsp_type     rsp_in;
   side_type    last;

   always_comb begin
      last = side_ff[PIPE_LEN-1];
      scaled = b10_ff * 8'd255;
      rsp_in.byte_offset = last.byte_offset;
      rsp_in.outside = last.outside;
      if (last.outside) begin
         rsp_in.alpha_byte = 8'd0;
      end else if (last.sat) begin
         rsp_in.alpha_byte = 8'd255;
      end else begin
         rsp_in.alpha_byte = scaled[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[PIPE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== bench/radial_falloff_alpha_tb.sv =====
// Self-checking testbench for the radial falloff alpha pipeline.
module radial_falloff_alpha_tb
   import rfa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 26;
   localparam int RANDOM_BEATS = 800;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_TEXTURE_WIDTH;
   logic [10:0] csr_wdata = '0;

   radial_falloff_alpha dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the two size registers.
   logic [10:0] tex_w, tex_h;
   rsp_type pixel_results[$];
   int errors = 0;
   int checked = 0;
   int outside_seen = 0;
   int clamp_seen = 0;
   longint cycles = 0;
   bit calm = 1'b0;

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] falloff(input logic [9:0] x, input logic [9:0] y,
                                          input logic [10:0] w);
      longint ex, ey;
      logic [63:0] d, reach, ratio, b, b2, b4, b8, b10;
      ex = 2 * longint'(x) - longint'(w);
      ey = 2 * longint'(y) - longint'(w);
      d = root64(64'(ex * ex + ey * ey) << 14);
      reach = root64((64'(w) * 64'(w)) << 15);
      if (reach == 0) return 8'd255;
      ratio = (d << 16) / reach;
      if (ratio >= 64'd131072 || ratio == 0) return 8'd255;
      b = (ratio <= 64'd65536) ? 64'd65536 - ratio : ratio - 64'd65536;
      if (b >= 64'd65536) return 8'd255;
      b2 = (b * b) >> 16;
      b4 = (b2 * b2) >> 16;
      b8 = (b4 * b4) >> 16;
      b10 = (b8 * b2) >> 16;
      return 8'((b10 * 255) >> 16);
   endfunction

   function automatic rsp_type predict_pixel(input req_type p);
      rsp_type r;
      r.outside = (p.pixel_x >= tex_w) || (p.pixel_y >= tex_h);
      r.alpha_byte = r.outside ? 8'd0 : falloff(p.pixel_x, p.pixel_y, tex_w);
      r.byte_offset = 22'((32'(p.pixel_x) + 32'(p.pixel_y) * 32'(tex_w)) * 4);
      return r;
   endfunction

   // Response side: random stall, checks each beat against the oldest prediction.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
         if (rsp_valid && !rsp_stall) begin
            if (pixel_results.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors = errors + 1;
            end else begin
               rsp_type e;
               e = pixel_results.pop_front();
               checked <= checked + 1;
               if (rsp_data.outside) outside_seen <= outside_seen + 1;
               if (!rsp_data.outside && rsp_data.alpha_byte == 8'd255)
                  clamp_seen <= clamp_seen + 1;
               if (rsp_data.alpha_byte !== e.alpha_byte) begin
                  $display("%0t: alpha_byte expected %0d actual %0d", $time,
                           e.alpha_byte, rsp_data.alpha_byte);
                  errors = errors + 1;
               end
               if (rsp_data.byte_offset !== e.byte_offset) begin
                  $display("%0t: byte_offset expected %0d actual %0d", $time,
                           e.byte_offset, rsp_data.byte_offset);
                  errors = errors + 1;
               end
               if (rsp_data.outside !== e.outside) begin
                  $display("%0t: outside expected %0d actual %0d", $time,
                           e.outside, rsp_data.outside);
                  errors = errors + 1;
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Drives one beat, holding it through stalls; gaps only when not calm.
   // Valid stays high after the beat so that a following beat can go back to back.
   task automatic send_pixel(input req_type p, input rsp_type known, input bit has_known);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      pixel_results.push_back(has_known ? known : predict_pixel(p));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pixel_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_size(input logic [1:0] idx, input logic [10:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_TEXTURE_WIDTH) tex_w = (v > SIZE_MAX) ? SIZE_MAX : v;
      else if (idx == REG_TEXTURE_HEIGHT) tex_h = (v > SIZE_MAX) ? SIZE_MAX : v;
   endtask

   typedef struct {
      logic [9:0] x;
      logic [9:0] y;
      bit         known;
      rsp_type    res;
   } pixel_row_type;

   pixel_row_type directed[] = '{
      '{10'd128, 10'd128, 1'b1, '{8'd255, 22'd131584, 1'b0}},  // exact center
      '{10'd0, 10'd0, 1'b1, '{8'd0, 22'd0, 1'b0}},              // corner
      '{10'd255, 10'd255, 1'b0, '0},
      '{10'd256, 10'd0, 1'b1, '{8'd0, 22'd1024, 1'b1}},         // past the right edge
      '{10'd0, 10'd256, 1'b1, '{8'd0, 22'd262144, 1'b1}},       // below the bottom
      '{10'd1023, 10'd1023, 1'b0, '0},
      '{10'd64, 10'd200, 1'b0, '0},
      '{10'd127, 10'd129, 1'b0, '0},
      '{10'd300, 10'd12, 1'b0, '0}
   };

   initial begin
      req_type p;
      logic [10:0] sizes[6][2];
      sizes = '{'{11'd1024, 11'd1024}, '{11'd1, 11'd1}, '{11'd2047, 11'd1500},
                '{11'd16, 11'd900}, '{11'd0, 11'd5}, '{11'd1000, 11'd0}};
      tex_w = SIZE_RESET;
      tex_h = SIZE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         p.pixel_x = directed[i].x;
         p.pixel_y = directed[i].y;
         send_pixel(p, directed[i].res, directed[i].known);
      end
      drain();

      // Unknown register indexes must leave both sizes alone.
      write_size(2'd2, 11'd7);
      write_size(2'd3, 11'd9);
      foreach (sizes[s]) begin
         write_size(REG_TEXTURE_WIDTH, sizes[s][0]);
         write_size(REG_TEXTURE_HEIGHT, sizes[s][1]);
         p = '{10'd0, 10'd0};      send_pixel(p, '0, 1'b0);
         p = '{10'd1023, 10'd1023}; send_pixel(p, '0, 1'b0);
         p.pixel_x = 10'(tex_w >> 1); p.pixel_y = 10'(tex_w >> 1);
         send_pixel(p, '0, 1'b0);
         p.pixel_x = 10'(tex_w >> 1); p.pixel_y = 10'(tex_h - 1);
         send_pixel(p, '0, 1'b0);
         drain();
      end

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 100 == 0) begin
            drain();
            case ($urandom_range(3))
               0: write_size(REG_TEXTURE_WIDTH, 11'($urandom_range(1, 1024)));
               1: write_size(REG_TEXTURE_HEIGHT, 11'($urandom_range(1, 1024)));
               2: write_size(REG_TEXTURE_WIDTH, 11'($urandom_range(0, 2047)));
               default: write_size(REG_TEXTURE_HEIGHT, 11'($urandom_range(2, 2047)));
            endcase
         end
         calm = (i >= 300 && i < 400);
         if ($urandom_range(9) < 7 && tex_w > 0 && tex_h > 0) begin
            p.pixel_x = 10'($urandom_range(0, (tex_w > 1024 ? 1024 : tex_w) - 1));
            p.pixel_y = 10'($urandom_range(0, (tex_h > 1024 ? 1024 : tex_h) - 1));
         end else begin
            p = req_type'(20'($urandom));
         end
         send_pixel(p, '0, 1'b0);
      end
      calm = 1'b0;
      drain();

      $display("Checked %0d pixels under the reset sizes, six fixed and eight random size",
               checked);
      $display("writes, with random stalls on both sides; %0d outside, %0d clamped.",
               outside_seen, clamp_seen);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rfa_pkg.sv
rtl/rfa_sqrt_pipe.sv
rtl/radial_falloff_alpha.sv
bench/radial_falloff_alpha_tb.sv
